// File: rtl/qgsu_pkg.sv
// ----------------------------------------------------------------------------
// qgsu_pkg
// Shared types and constants for the quantized gated state update unit.
// ----------------------------------------------------------------------------
package qgsu_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned IDX_W   = 13;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned REG_W   = 32;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned ENC_W   = 7;
  localparam int unsigned SOUL_W  = 6;
  localparam int unsigned EIDX_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_WEIGHT = 3'd0,
    CMD_WR_BIAS   = 3'd1,
    CMD_WR_ENC    = 3'd2,
    CMD_WR_STATE  = 3'd3,
    CMD_RUN       = 3'd4
  } cmd_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_WSCALE = 3'd0,
    REG_WZERO  = 3'd1,
    REG_BSCALE = 3'd2,
    REG_BZERO  = 3'd3,
    REG_ENCLEN = 3'd4,
    REG_SOULLEN = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BIAS_RD,
    ST_BIAS_DQ,
    ST_BIAS_ADD,
    ST_MAC_RD,
    ST_MAC_DQ,
    ST_MAC_MUL,
    ST_MAC_ACC,
    ST_ROW_END,
    ST_UPD_RD,
    ST_UPD_ACT,
    ST_UPD_MIX,
    ST_UPD_OUT
  } state_t;

  // Sigmoid table, Q0.12, sigmoid(0..8)
  function automatic logic [12:0] sig_tab(input logic [3:0] k);
    case (k)
      4'd0:    sig_tab = 13'd2048;
      4'd1:    sig_tab = 13'd2994;
      4'd2:    sig_tab = 13'd3608;
      4'd3:    sig_tab = 13'd3902;
      4'd4:    sig_tab = 13'd4022;
      4'd5:    sig_tab = 13'd4069;
      4'd6:    sig_tab = 13'd4086;
      4'd7:    sig_tab = 13'd4092;
      default: sig_tab = 13'd4095;
    endcase
  endfunction

  // Piecewise-linear sigmoid of a signed Q18.16 value (34 bits), Q0.12 out
  function automatic logic [12:0] sigmoid_q12(input logic signed [33:0] x);
    logic [33:0] a;
    logic [3:0]  k;
    logic [15:0] f;
    logic [12:0] t0;
    logic [12:0] d;
    logic [28:0] pr;
    logic [12:0] y;
    a  = x[33] ? 34'(-x) : 34'(x);
    k  = a[19:16];
    f  = a[15:0];
    t0 = sig_tab(k);
    d  = 13'(sig_tab(4'(k + 4'd1)) - t0);
    pr = 29'(d) * 29'(f);
    if (a[33:19] != '0) y = sig_tab(4'd8);
    else y = 13'(t0 + 13'(pr[28:16]));
    sigmoid_q12 = x[33] ? 13'(13'd4096 - y) : y;
  endfunction

endpackage

// File: rtl/qgsu_act.sv
// ----------------------------------------------------------------------------
// qgsu_act
// Registered sigmoid and tanh of two Q16.16 pre-activations.
// ----------------------------------------------------------------------------
module qgsu_act (
  input  logic                clk,
  input  logic signed [31:0]  gate_pre,
  input  logic signed [31:0]  upd_pre,
  output logic        [12:0]  gate_q,
  output logic signed [13:0]  upd_q
);
  import qgsu_pkg::*;

  logic [12:0] gate_r;
  logic [12:0] usig_r;

  always_ff @(posedge clk) begin
    gate_r <= sigmoid_q12(34'(gate_pre));
    usig_r <= sigmoid_q12({upd_pre[31], upd_pre, 1'b0});
  end

  assign gate_q = gate_r;
  assign upd_q  = 14'(signed'({1'b0, usig_r, 1'b0})) - 14'sd4096;
endmodule

// File: rtl/quantized_gated_state_update_unit.sv
// ----------------------------------------------------------------------------
// quantized_gated_state_update_unit
// Int8 dequantized mat-vec over encoder and state vectors with a gated
// state update; weights, biases, vectors and pre-activations in memories.
// Load word: written as it is accepted; busy stays low, so loads go back to back.
// Run word: busy for 2*soul_len rows (bias read/dequant/add, then read/dequant/
// multiply/accumulate per column, row end), then an update per state element.
// One result word per updated element, shown for one cycle; no stall.
// Reset clears control and the state vector (valid bits), not the stores.
// ----------------------------------------------------------------------------
module quantized_gated_state_update_unit #(
  parameter int unsigned ENC_MAX  = 64,
  parameter int unsigned SOUL_MAX = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [qgsu_pkg::CMD_W-1:0]         in_cmd,
  input  logic [qgsu_pkg::IDX_W-1:0]         in_index,
  input  logic signed [qgsu_pkg::VAL_W-1:0]  in_value,
  input  logic                               cfg_we,
  input  logic [qgsu_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [qgsu_pkg::REG_W-1:0]         cfg_data,
  output logic                               out_valid,
  output logic [$clog2(SOUL_MAX)-1:0]        out_elem_index,
  output logic signed [qgsu_pkg::VAL_W-1:0]  out_elem_value,
  output logic                               out_last
);
  import qgsu_pkg::*;

  localparam int unsigned ROW_MAX = 2 * SOUL_MAX;
  localparam int unsigned WDEPTH  = ROW_MAX * (ENC_MAX + SOUL_MAX);
  localparam int unsigned WA_W    = $clog2(WDEPTH);
  localparam int unsigned EA_W    = (ENC_MAX > 1) ? $clog2(ENC_MAX) : 1;
  localparam int unsigned SA_W    = (SOUL_MAX > 1) ? $clog2(SOUL_MAX) : 1;
  localparam int unsigned RA_W    = $clog2(ROW_MAX);
  localparam int unsigned EC_W    = $clog2(ENC_MAX + 1);
  localparam int unsigned SC_W    = $clog2(SOUL_MAX + 1);
  localparam int unsigned CC_W    = $clog2(ENC_MAX + SOUL_MAX + 1);
  localparam int unsigned RC_W    = $clog2(ROW_MAX + 1);

  // memories
  logic [7:0]               wmem [WDEPTH];
  logic [7:0]               bmem [ROW_MAX];
  logic signed [15:0]       emem [ENC_MAX];
  logic signed [15:0]       smem [SOUL_MAX];
  logic signed [31:0]       pmem [ROW_MAX];
  logic [SOUL_MAX-1:0]      svalid_r;

  logic signed [31:0] wscale_r, wzero_r, bscale_r, bzero_r;
  logic [ENC_W-1:0]   enclen_r;
  logic [SOUL_W-1:0]  soullen_r;

  state_t state_r, state_nxt;
  logic [RC_W-1:0]   row_r, row_nxt;
  logic [CC_W-1:0]   col_r, col_nxt;
  logic [WA_W:0]     waddr_r, waddr_nxt;
  logic signed [31:0] acc_r, acc_nxt;

  logic [EC_W-1:0] e_eff;
  logic [SC_W-1:0] s_eff;
  logic [CC_W-1:0] cols;

  assign e_eff = (EC_W'(enclen_r) > EC_W'(ENC_MAX)) ? EC_W'(ENC_MAX) : EC_W'(enclen_r);
  assign s_eff = (SC_W'(soullen_r) > SC_W'(SOUL_MAX)) ? SC_W'(SOUL_MAX)
                                                      : SC_W'(soullen_r);
  assign cols  = CC_W'(e_eff) + CC_W'(s_eff);

  logic accept;
  assign accept = start && !busy;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wscale_r  <= 32'sd256;
      wzero_r   <= '0;
      bscale_r  <= 32'sd256;
      bzero_r   <= '0;
      enclen_r  <= ENC_W'(64);
      soullen_r <= SOUL_W'(32);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WSCALE:  wscale_r  <= cfg_data;
        REG_WZERO:   wzero_r   <= cfg_data;
        REG_BSCALE:  bscale_r  <= cfg_data;
        REG_BZERO:   bzero_r   <= cfg_data;
        REG_ENCLEN:  enclen_r  <= cfg_data[ENC_W-1:0];
        REG_SOULLEN: soullen_r <= cfg_data[SOUL_W-1:0];
        default: ;
      endcase
    end
  end

  // read ports
  logic [7:0]         wrd_r, brd_r;
  logic signed [15:0] xrd_r, ord_r;
  logic signed [31:0] gp_r, up_r;
  logic               xst_r, ovl_r;
  logic               rd_w, rd_b, rd_x, rd_upd;
  logic [WA_W-1:0]    rw_a;
  logic [RA_W-1:0]    rb_a;
  logic               x_enc;
  logic [EA_W-1:0]    xe_a;
  logic [SA_W-1:0]    xs_a, ui_a;
  logic [CC_W-1:0]    cm_e;

  assign cm_e  = col_r - CC_W'(e_eff);
  assign x_enc = col_r < CC_W'(e_eff);
  assign rw_a  = waddr_r[WA_W-1:0];
  assign rb_a  = row_r[RA_W-1:0];
  assign xe_a  = col_r[EA_W-1:0];
  assign xs_a  = cm_e[SA_W-1:0];
  assign ui_a  = row_r[SA_W-1:0];

  always_ff @(posedge clk) begin
    if (rd_w) wrd_r <= wmem[rw_a];
    if (rd_b) brd_r <= bmem[rb_a];
    if (rd_x) begin
      xst_r <= !x_enc;
      xrd_r <= x_enc ? emem[xe_a] : smem[xs_a];
      ovl_r <= svalid_r[xs_a];
    end
    if (rd_upd) begin
      gp_r  <= pmem[rb_a];
      up_r  <= pmem[RA_W'(row_r + RC_W'(s_eff))];
      ord_r <= smem[ui_a];
      ovl_r <= svalid_r[ui_a];
    end
  end

  logic signed [15:0] xval;
  assign xval = (xst_r && !ovl_r) ? 16'sd0 : xrd_r;

  // dequant and multiply pipeline
  logic signed [41:0] dq_r;
  logic signed [57:0] prod_r;
  logic signed [57:0] prod_w;
  logic signed [15:0] x_r;
  logic signed [8:0]  qs;
  logic signed [41:0] dqw;
  logic               is_bias;

  assign is_bias = (state_r == ST_BIAS_DQ);
  assign qs = 9'(signed'(is_bias ? brd_r : wrd_r)) + 9'sd128;
  assign dqw = 42'(qs) * 42'(is_bias ? bscale_r : wscale_r)
             + 42'(is_bias ? bzero_r : wzero_r);
  assign prod_w = dq_r * x_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_BIAS_DQ || state_r == ST_MAC_DQ) begin
      dq_r <= dqw;
      x_r  <= xval;
    end
    if (state_r == ST_MAC_MUL) prod_r <= prod_w;
  end

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) sat32 = 32'sh7fffffff;
    else if (v < -64'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

  // activations
  logic [12:0]        gq;
  logic signed [13:0] uq;
  qgsu_act u_act (.clk(clk), .gate_pre(gp_r), .upd_pre(up_r), .gate_q(gq), .upd_q(uq));

  logic signed [15:0] oldv;
  logic signed [31:0] mix_r;
  logic signed [15:0] newv;
  assign oldv = ovl_r ? ord_r : 16'sd0;
  always_ff @(posedge clk) begin
    if (state_r == ST_UPD_MIX)
      mix_r <= 32'(signed'({1'b0, gq})) * 32'(oldv)
             + 32'(signed'({1'b0, 13'(13'd4096 - gq)})) * 32'(uq);
  end
  assign newv = (signed'(mix_r[31:12]) > 20'sd32767) ? 16'sh7fff :
                (signed'(mix_r[31:12]) < -20'sd32768) ? 16'sh8000 : mix_r[27:12];

  // writes
  always_ff @(posedge clk) begin
    if (accept && in_cmd == CMD_WR_WEIGHT && 32'(in_index) < WDEPTH)
      wmem[WA_W'(in_index)] <= in_value[7:0];
    if (accept && in_cmd == CMD_WR_BIAS && 32'(in_index) < ROW_MAX)
      bmem[RA_W'(in_index)] <= in_value[7:0];
    if (accept && in_cmd == CMD_WR_ENC && 32'(in_index) < ENC_MAX)
      emem[EA_W'(in_index)] <= in_value;
    if (accept && in_cmd == CMD_WR_STATE && 32'(in_index) < SOUL_MAX)
      smem[SA_W'(in_index)] <= in_value;
    else if (state_r == ST_UPD_OUT)
      smem[ui_a] <= newv;
    if (state_r == ST_ROW_END) pmem[rb_a] <= acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) svalid_r <= '0;
    else if (accept && in_cmd == CMD_WR_STATE && 32'(in_index) < SOUL_MAX)
      svalid_r[SA_W'(in_index)] <= 1'b1;
    else if (state_r == ST_UPD_OUT)
      svalid_r[ui_a] <= 1'b1;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      row_r   <= '0;
      col_r   <= '0;
      waddr_r <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      waddr_r <= waddr_nxt;
    end
    acc_r <= acc_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    waddr_nxt = waddr_r;
    acc_nxt   = acc_r;
    rd_w = 1'b0; rd_b = 1'b0; rd_x = 1'b0; rd_upd = 1'b0;
    busy      = (state_r != ST_IDLE);
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_cmd == CMD_RUN && s_eff != '0) begin
          row_nxt = '0; waddr_nxt = '0; state_nxt = ST_BIAS_RD;
        end
      end
      ST_BIAS_RD: begin rd_b = 1'b1; col_nxt = '0; state_nxt = ST_BIAS_DQ; end
      ST_BIAS_DQ: state_nxt = ST_BIAS_ADD;
      ST_BIAS_ADD: begin acc_nxt = sat32(64'(dq_r)); state_nxt = ST_MAC_RD; end
      ST_MAC_RD: begin rd_w = 1'b1; rd_x = 1'b1; state_nxt = ST_MAC_DQ; end
      ST_MAC_DQ: state_nxt = ST_MAC_MUL;
      ST_MAC_MUL: state_nxt = ST_MAC_ACC;
      ST_MAC_ACC: begin
        acc_nxt   = sat32(64'(acc_r) + 64'(prod_r >>> 12));
        waddr_nxt = waddr_r + 1'b1;
        col_nxt   = col_r + 1'b1;
        state_nxt = (col_r + 1'b1 == cols) ? ST_ROW_END : ST_MAC_RD;
      end
      ST_ROW_END: begin
        row_nxt = row_r + 1'b1;
        if (row_r + 1'b1 == RC_W'({s_eff, 1'b0})) begin
          row_nxt = '0; state_nxt = ST_UPD_RD;
        end else state_nxt = ST_BIAS_RD;
      end
      ST_UPD_RD: begin rd_upd = 1'b1; state_nxt = ST_UPD_ACT; end
      ST_UPD_ACT: state_nxt = ST_UPD_MIX;
      ST_UPD_MIX: state_nxt = ST_UPD_OUT;
      ST_UPD_OUT: begin
        out_valid = 1'b1;
        row_nxt   = row_r + 1'b1;
        state_nxt = (row_r + 1'b1 == RC_W'(s_eff)) ? ST_IDLE : ST_UPD_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_elem_index = row_r[SA_W-1:0];
  assign out_elem_value = newv;
  assign out_last       = (row_r + 1'b1 == RC_W'(s_eff));

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside a run");
  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !busy) else $error("run did not end on last");
  a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC_ACC) |-> busy) else $error("accept during mac");
endmodule

// File: bench/qgsu_checker.sv
// ----------------------------------------------------------------------------
// qgsu_checker
// Watches the command, register and result channels of the gated state
// update unit, keeps its own copy of the stores and registers, works out the
// updated state elements of each run word and compares every result word.
// ----------------------------------------------------------------------------
module qgsu_checker
  import qgsu_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic [IDX_W-1:0]         in_index,
  input  logic signed [VAL_W-1:0]  in_value,
  input  logic                     cfg_we,
  input  logic [CIDX_W-1:0]        cfg_index,
  input  logic [REG_W-1:0]         cfg_data,
  input  logic                     out_valid,
  input  logic [EIDX_W-1:0]        out_elem_index,
  input  logic signed [VAL_W-1:0]  out_elem_value,
  input  logic                     out_last,
  output int                       fail_count,
  output int                       pending
);

  localparam int ENC_CAP  = 64;
  localparam int SOUL_CAP = 32;
  localparam int W_DEPTH  = 2 * SOUL_CAP * (ENC_CAP + SOUL_CAP);
  localparam int SIG_PTS[9] = '{2048, 2994, 3608, 3902, 4022, 4069, 4086, 4092, 4095};

  typedef struct {
    logic [EIDX_W-1:0]        idx;
    logic signed [VAL_W-1:0]  val;
    logic                     last;
  } elem_word_t;

  logic [7:0]               weights [W_DEPTH];
  logic [7:0]               biases [2*SOUL_CAP];
  logic signed [VAL_W-1:0]  enc_vec [ENC_CAP];
  logic signed [VAL_W-1:0]  soul_vec [SOUL_CAP];
  longint                   preact [2*SOUL_CAP];
  longint                   w_scale, w_zero, b_scale, b_zero;
  int                       enc_len, soul_len;
  elem_word_t               elem_q [$];

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint dequant(logic [7:0] q, longint scale, longint zero);
    return (longint'($signed(q)) + 128) * scale + zero;
  endfunction

  function automatic int gate_curve(longint x);
    longint a;
    longint f;
    int     k;
    int     y;
    a = x < 0 ? -x : x;
    if (a >= (longint'(8) << 16)) begin
      y = SIG_PTS[8];
    end else begin
      k = int'(a >> 16);
      f = a & 64'hFFFF;
      y = SIG_PTS[k] + int'((longint'(SIG_PTS[k+1] - SIG_PTS[k]) * f) >> 16);
    end
    return x < 0 ? 4096 - y : y;
  endfunction

  task automatic report(string what, longint want, longint got);
    $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    fail_count++;
  endtask

  task automatic update_state();
    int         e, s, cols;
    longint     acc, xv, w, g, u, mix, nv;
    elem_word_t wd;
    e = enc_len > ENC_CAP ? ENC_CAP : enc_len;
    s = soul_len > SOUL_CAP ? SOUL_CAP : soul_len;
    cols = e + s;
    for (int r = 0; r < 2 * s; r++) begin
      acc = clamp(dequant(biases[r], b_scale, b_zero), -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
      for (int c = 0; c < cols; c++) begin
        xv = c < e ? longint'(enc_vec[c]) : longint'(soul_vec[c-e]);
        w = dequant(weights[r*cols+c], w_scale, w_zero);
        acc = clamp(acc + ((w * xv) >>> 12), -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
      end
      preact[r] = acc;
    end
    for (int i = 0; i < s; i++) begin
      g = gate_curve(preact[i]);
      u = 2 * gate_curve(2 * preact[s+i]) - 4096;
      mix = g * longint'(soul_vec[i]) + (4096 - g) * u;
      nv = clamp(mix >>> 12, -32768, 32767);
      soul_vec[i] = VAL_W'(nv);
      wd.idx = EIDX_W'(i);
      wd.val = VAL_W'(nv);
      wd.last = (i + 1 == s);
      elem_q.push_back(wd);
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    elem_word_t wd;
    if (!rst_n) begin
      foreach (soul_vec[i]) soul_vec[i] = '0;
      w_scale = 256;
      w_zero = 0;
      b_scale = 256;
      b_zero = 0;
      enc_len = 64;
      soul_len = 32;
      elem_q.delete();
    end else begin
      if (out_valid) begin
        if (elem_q.size() == 0) begin
          $display("%0t: result word with nothing expected, index %0d value %0d",
                   $realtime, out_elem_index, out_elem_value);
          fail_count++;
        end else begin
          wd = elem_q.pop_front();
          if (out_elem_index !== wd.idx) report("elem_index", wd.idx, out_elem_index);
          if (out_elem_value !== wd.val) report("elem_value", wd.val, out_elem_value);
          if (out_last !== wd.last) report("last", wd.last, out_last);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_WSCALE:  w_scale = longint'($signed(cfg_data));
          REG_WZERO:   w_zero = longint'($signed(cfg_data));
          REG_BSCALE:  b_scale = longint'($signed(cfg_data));
          REG_BZERO:   b_zero = longint'($signed(cfg_data));
          REG_ENCLEN:  enc_len = int'(cfg_data[ENC_W-1:0]);
          REG_SOULLEN: soul_len = int'(cfg_data[SOUL_W-1:0]);
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (in_cmd)
          CMD_WR_WEIGHT: if (in_index < W_DEPTH) weights[in_index] = in_value[7:0];
          CMD_WR_BIAS:   if (in_index < 2 * SOUL_CAP) biases[in_index] = in_value[7:0];
          CMD_WR_ENC:    if (in_index < ENC_CAP) enc_vec[in_index] = in_value;
          CMD_WR_STATE:  if (in_index < SOUL_CAP) soul_vec[in_index] = in_value;
          CMD_RUN:       update_state();
          default: ;
        endcase
      end
    end
    pending = elem_q.size();
  end

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives load, run and register words into the gated state update unit:
// a preload of the store entries the runs read, a directed pass over edge
// values and ignored words, then randomised phases under several register
// settings.
// The checker beside the block predicts and compares; this gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import qgsu_pkg::*;

  localparam int            W_PRE      = 64;
  localparam int            B_PRE      = 10;
  localparam int            E_PRE      = 4;
  localparam int            IDLE_LIMIT = 5000;
  localparam logic [2:0]    CMD_SPARE  = 3'd5;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [CMD_W-1:0]         in_cmd = '0;
  logic [IDX_W-1:0]         in_index = '0;
  logic signed [VAL_W-1:0]  in_value = '0;
  logic                     cfg_we = 1'b0;
  logic [CIDX_W-1:0]        cfg_index = '0;
  logic [REG_W-1:0]         cfg_data = '0;
  logic                     out_valid;
  logic [EIDX_W-1:0]        out_elem_index;
  logic signed [VAL_W-1:0]  out_elem_value;
  logic                     out_last;
  int                       fail_count;
  int                       pending;
  int                       quiet_cycles = 0;
  int                       gap_pct = 32;
  int                       enc_set = 64;
  int                       soul_set = 32;
  int                       word_no = 0;

  always #5 clk = ~clk;

  quantized_gated_state_update_unit uut (
    .clk, .rst_n, .start, .busy, .in_cmd, .in_index, .in_value,
    .cfg_we, .cfg_index, .cfg_data,
    .out_valid, .out_elem_index, .out_elem_value, .out_last
  );

  qgsu_checker u_checker (
    .clk, .rst_n, .start, .busy, .in_cmd, .in_index, .in_value,
    .cfg_we, .cfg_index, .cfg_data,
    .out_valid, .out_elem_index, .out_elem_value, .out_last,
    .fail_count, .pending
  );

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send(logic [CMD_W-1:0] c, logic [IDX_W-1:0] i, logic [VAL_W-1:0] v);
    gap_pct = (word_no < 58) ? 32 : ((word_no < 116) ? 47 : 0);
    word_no++;
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    in_cmd <= c;
    in_index <= i;
    in_value <= v;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, logic [REG_W-1:0] d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(int ws, int wz, int bs, int bz, int e, int s);
    drain();
    write_reg(REG_WSCALE, ws);
    write_reg(REG_WZERO, wz);
    write_reg(REG_BSCALE, bs);
    write_reg(REG_BZERO, bz);
    write_reg(REG_ENCLEN, e);
    write_reg(REG_SOULLEN, s);
    enc_set = e > 64 ? 64 : e;
    soul_set = s > 32 ? 32 : s;
  endtask

  function automatic logic [VAL_W-1:0] int8_value();
    if ($urandom_range(9) == 0) return VAL_W'($urandom);
    return VAL_W'($signed(8'($urandom)));
  endfunction

  task automatic random_word();
    int          pick;
    int          span;
    logic [IDX_W-1:0] idx;
    pick = $urandom_range(99);
    span = 2 * soul_set * (enc_set + soul_set);
    if (pick < 35) begin
      idx = $urandom_range(9) == 0 ? IDX_W'($urandom) : IDX_W'($urandom_range(soul_set - 1));
      send(CMD_WR_STATE, idx, VAL_W'($urandom));
    end else if (pick < 50) begin
      idx = $urandom_range(9) == 0 ? IDX_W'($urandom) : IDX_W'($urandom_range(63));
      send(CMD_WR_ENC, idx, VAL_W'($urandom));
    end else if (pick < 70) begin
      idx = ($urandom_range(9) == 0 || span == 0) ? IDX_W'($urandom)
                                                  : IDX_W'($urandom_range(span - 1));
      send(CMD_WR_WEIGHT, idx, int8_value());
    end else if (pick < 82) begin
      idx = $urandom_range(9) == 0 ? IDX_W'($urandom) : IDX_W'($urandom_range(63));
      send(CMD_WR_BIAS, idx, int8_value());
    end else if (pick < 97) begin
      send(CMD_RUN, IDX_W'($urandom), VAL_W'($urandom));
    end else begin
      send(CMD_SPARE + 3'($urandom_range(2)), IDX_W'($urandom), VAL_W'($urandom));
    end
  endtask

  task automatic phase(int ws, int wz, int bs, int bz, int e, int s, int n);
    set_regs(ws, wz, bs, bz, e, s);
    repeat (n) random_word();
    send(CMD_RUN, '0, '0);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < W_PRE; i++) send(CMD_WR_WEIGHT, IDX_W'(i), int8_value());
    for (int i = 0; i < B_PRE; i++) send(CMD_WR_BIAS, IDX_W'(i), int8_value());
    for (int i = 0; i < E_PRE; i++) send(CMD_WR_ENC, IDX_W'(i), VAL_W'($urandom_range(8191) - 4096));

    set_regs(256, 0, 256, 0, 4, 4);
    send(CMD_WR_WEIGHT, 13'd0, 16'sh7F80);
    send(CMD_WR_WEIGHT, 13'd6143, 16'sh007F);
    send(CMD_WR_WEIGHT, 13'd8191, 16'sh0011);
    send(CMD_WR_WEIGHT, 13'd6144, 16'sh0022);
    send(CMD_WR_BIAS, 13'd0, 16'sh007F);
    send(CMD_WR_BIAS, 13'd63, 16'shFF80);
    send(CMD_WR_BIAS, 13'd64, 16'sh0033);
    send(CMD_WR_ENC, 13'd0, 16'sh7FFF);
    send(CMD_WR_ENC, 13'd63, 16'sh8000);
    send(CMD_WR_ENC, 13'd64, 16'sh1234);
    send(CMD_WR_STATE, 13'd0, 16'sh7FFF);
    send(CMD_WR_STATE, 13'd31, 16'sh8000);
    send(CMD_WR_STATE, 13'd32, 16'sh4321);
    send(CMD_WR_STATE, 13'd8191, 16'shFFFF);
    send(CMD_SPARE, 13'd5, 16'sh0001);
    send(CMD_SPARE + 3'd1, 13'h1AAA, 16'sh5555);
    send(CMD_SPARE + 3'd2, 13'h1FFF, 16'shAAAA);
    send(CMD_RUN, '0, '0);
    send(CMD_WR_STATE, 13'd1, 16'sh0800);
    send(CMD_RUN, 13'h1FFF, 16'shFFFF);

    phase(256, 0, 256, 0, 4, 3, 10);
    phase(32'h0001_0000, -32'sh8000, 32'h0002_0000, 32'h1000, 4, 4, 10);
    phase(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 2, 4, 8);
    phase(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 1, 6);
    phase(3000, -50000, -4000, 12345, 0, 5, 8);
    phase(512, 100, 512, -100, 16, 0, 6);
    phase($urandom_range(20000) - 10000, $urandom_range(200000) - 100000,
          $urandom_range(20000) - 10000, $urandom_range(200000) - 100000,
          $urandom_range(1, 3), $urandom_range(1, 4), 12);
    phase(100, 0, 100, 0, 3, 4, 10);

    drain();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/qgsu_pkg.sv
rtl/qgsu_act.sv
rtl/quantized_gated_state_update_unit.sv
bench/qgsu_checker.sv
bench/testbench.sv
